FILE: hdl/assert_macros.svh
// Assertion helper macros shared by the speed controller RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: hdl/espc_pkg.sv
// Package for the encoder speed PID controller: widths, constants, control types.
// No dependencies.
package espc_pkg;
	localparam int RING_DEPTH_DEF = 8;
	localparam int TIME_BITS_DEF  = 32;
	localparam int RPM_MAX        = 8388607;
	localparam int RPM_MIN        = -8388608;
	localparam int INTEG_LIMIT    = 25600;

	localparam logic [2:0] REG_TARGET = 3'd0;
	localparam logic [2:0] REG_GAIN_P = 3'd1;
	localparam logic [2:0] REG_GAIN_I = 3'd2;
	localparam logic [2:0] REG_GAIN_D = 3'd3;
	localparam logic [2:0] REG_ALPHA  = 3'd4;
	localparam logic [2:0] REG_BOUNCE = 3'd5;
	localparam logic [2:0] REG_STALE  = 3'd6;
	localparam logic [2:0] REG_SCALE  = 3'd7;

	typedef struct packed {
		logic edge_upd;
		logic sum_clr;
		logic sum_step;
		logic avg_start;
		logic quo_start;
		logic raw_load;
		logic ema;
		logic err;
		logic mul_p;
		logic mul_i;
		logic mul_d;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic sum_last;
		logic div_busy;
		logic div_done;
	} sts_t;
endpackage

FILE: hdl/espc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing beyond its parameter.
module espc_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] quo
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] rem_q, num_q, den_q;
	logic [CW-1:0] cnt_q;
	logic [W:0] trial;
	always_comb trial = {rem_q, num_q[W-1]} - {1'b0, den_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				cnt_q <= CW'(W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) done <= 1'b1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[W-2:0], ~trial[W]};
			if (!trial[W]) rem_q <= trial[W-1:0];
			else rem_q <= {rem_q[W-2:0], num_q[W-1]};
		end
	end
	assign busy = cnt_q != '0;
	assign quo  = num_q;
endmodule

FILE: hdl/espc_datapath.sv
// Datapath: edge ring, averaging, speed division, EMA and PID arithmetic.
// Depends on espc_pkg, espc_div and assert_macros.svh.
`include "assert_macros.svh"
module espc_datapath #(
	parameter int RING_DEPTH = espc_pkg::RING_DEPTH_DEF,
	parameter int TIME_BITS  = espc_pkg::TIME_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  espc_pkg::cmd_t         cmd,
	output espc_pkg::sts_t         sts,
	input  logic [TIME_BITS-1:0]   time_in,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_idx,
	input  logic [31:0]            cfg_data,
	output logic [7:0]             duty,
	output logic signed [23:0]     rpm_filtered
);
	localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam int SW = TIME_BITS + CW;
	localparam int DW = (SW > 32) ? SW : 32;
	localparam logic signed [63:0] U_MAX = 64'sd255 <<< 24;

	logic [15:0] target_q, bounce_q;
	logic [23:0] gp_q, gi_q, gd_q;
	logic [8:0]  alpha_q;
	logic [31:0] stale_q, scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= 16'd11520; gp_q <= 24'd98304; gi_q <= 24'd104858;
			gd_q <= 24'd98; alpha_q <= 9'd77; bounce_q <= 16'd200;
			stale_q <= 32'd200000; scale_q <= 32'd20425532;
		end else if (cfg_we) begin
			case (cfg_idx)
				espc_pkg::REG_TARGET: target_q <= cfg_data[15:0];
				espc_pkg::REG_GAIN_P: gp_q     <= cfg_data[23:0];
				espc_pkg::REG_GAIN_I: gi_q     <= cfg_data[23:0];
				espc_pkg::REG_GAIN_D: gd_q     <= cfg_data[23:0];
				espc_pkg::REG_ALPHA:  alpha_q  <= cfg_data[8:0];
				espc_pkg::REG_BOUNCE: bounce_q <= cfg_data[15:0];
				espc_pkg::REG_STALE:  stale_q  <= cfg_data;
				espc_pkg::REG_SCALE:  scale_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [TIME_BITS-1:0] ring_q [RING_DEPTH];
	logic [IW-1:0] widx_q, sidx_q;
	logic [TIME_BITS-1:0] last_q, period;
	logic seen_q;
	logic [SW-1:0] sum_q;
	logic [CW-1:0] cnt_q;
	logic live_q;
	logic [TIME_BITS-1:0] ring_rd;

	assign period  = time_in - last_q;
	assign ring_rd = ring_q[sidx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++) ring_q[i] <= '0;
			widx_q <= '0; last_q <= '0; seen_q <= 1'b0;
		end else if (cmd.edge_upd) begin
			last_q <= time_in;
			if (period > TIME_BITS'(bounce_q)) begin
				ring_q[widx_q] <= period;
				widx_q <= (widx_q == IW'(RING_DEPTH - 1)) ? '0 : widx_q + 1'b1;
				seen_q <= 1'b1;
			end
		end
	end

	logic div_start, div_busy, div_done;
	logic [DW-1:0] div_num, div_den, div_quo;
	logic [DW-1:0] avg_q;
	logic signed [24:0] raw_q;
	logic signed [24:0] rpm_q;
	logic signed [23:0] rpm_out_q;
	logic signed [24:0] err_q, prev_q;
	logic signed [24:0] integ_q;
	logic signed [63:0] u_q;

	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			sum_q <= '0; cnt_q <= '0; sidx_q <= '0;
			live_q <= seen_q && (DW'(TIME_BITS'(time_in - last_q)) <= DW'(stale_q));
		end else if (cmd.sum_step) begin
			if (ring_rd != '0) begin
				sum_q <= sum_q + SW'(ring_rd);
				cnt_q <= cnt_q + 1'b1;
			end
			sidx_q <= (sidx_q == IW'(RING_DEPTH - 1)) ? '0 : sidx_q + 1'b1;
		end
		if (cmd.quo_start) avg_q <= div_quo;
	end

	always_comb begin
		div_start = cmd.avg_start || cmd.quo_start;
		if (cmd.avg_start) begin
			div_num = DW'(sum_q);
			div_den = (cnt_q == '0) ? DW'(1) : DW'(cnt_q);
		end else begin
			div_num = DW'(scale_q);
			div_den = (div_quo == '0) ? DW'(1) : div_quo;
		end
	end

	espc_div #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .busy(div_busy), .done(div_done), .quo(div_quo)
	);

	logic [9:0] alpha_c;
	logic signed [26:0] ema_diff;
	logic signed [37:0] ema_prod;
	logic signed [25:0] ema_new;
	logic signed [25:0] err_raw;
	logic signed [29:0] dlt;
	logic signed [63:0] term;
	logic signed [25:0] integ_new;
	logic signed [24:0] err_q4;
	logic [22:0] div5_in;
	logic [47:0] div5_prod;
	logic signed [24:0] floor20;

	always_comb begin
		alpha_c  = (alpha_q > 9'd256) ? 10'd256 : {1'b0, alpha_q};
		ema_diff = 27'(raw_q) - 27'(rpm_q);
		ema_prod = 38'(ema_diff) * $signed({1'b0, alpha_c});
		ema_new  = 26'(rpm_q) + 26'(ema_prod >>> 8);
		err_raw  = $signed({10'd0, target_q}) - 26'(rpm_q);
		dlt      = (30'(err_q) - 30'(prev_q)) * 30'sd20;
		term     = '0;
		if (cmd.mul_p) term = 64'(err_q) * $signed({1'b0, gp_q});
		if (cmd.mul_i) term = 64'(integ_q) * $signed({1'b0, gi_q});
		if (cmd.mul_d) term = 64'(dlt) * $signed({1'b0, gd_q});
		// floor(err / 20) = floor(floor(err / 4) / 5); offset keeps the divide by 5 unsigned
		err_q4    = err_q >>> 2;
		div5_in   = 23'(err_q4 + 25'sd5242880);
		div5_prod = 48'(div5_in) * 48'd13421773;
		floor20   = $signed(25'(div5_prod[47:26])) - 25'sd1048576;
		integ_new = 26'(integ_q) + 26'(floor20);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_q <= '0; integ_q <= '0; prev_q <= '0;
			duty <= '0; rpm_out_q <= '0;
		end else begin
			if (cmd.ema) begin
				if (ema_new > 26'sd8388607) rpm_q <= 25'sd8388607;
				else if (ema_new < -26'sd8388608) rpm_q <= -25'sd8388608;
				else rpm_q <= 25'(ema_new);
			end
			if (cmd.finish) begin
				prev_q <= err_q;
				rpm_out_q <= 24'(rpm_q);
				if (u_q > 0 && u_q < U_MAX) begin
					if (integ_new > 26'sd25600) integ_q <= 25'sd25600;
					else if (integ_new < -26'sd25600) integ_q <= -25'sd25600;
					else integ_q <= 25'(integ_new);
				end
				if (u_q <= 0) duty <= 8'd0;
				else if (u_q >= U_MAX) duty <= 8'd255;
				else duty <= u_q[31:24];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.raw_load) begin
			if (!live_q || cnt_q == '0) raw_q <= '0;
			else if (avg_q == '0) raw_q <= 25'sd8388607;
			else if (div_quo > DW'(espc_pkg::RPM_MAX)) raw_q <= 25'sd8388607;
			else raw_q <= 25'(div_quo);
		end
		if (cmd.err) begin
			if (err_raw > 26'sd8388607) err_q <= 25'sd8388607;
			else err_q <= 25'(err_raw);
			u_q <= '0;
		end
		if (cmd.mul_p || cmd.mul_i || cmd.mul_d) u_q <= u_q + term;
	end

	assign sts.sum_last = sidx_q == IW'(RING_DEPTH - 1);
	assign sts.div_busy = div_busy;
	assign sts.div_done = div_done;
	assign rpm_filtered = rpm_out_q;

	`ASSERT_IMPL(a_integ_range, clk, arst_n, 1'b1,
		integ_q <= 25'sd25600 && integ_q >= -25'sd25600, "integral out of range")
	`ASSERT_IMPL(a_rpm_range, clk, arst_n, 1'b1,
		rpm_q <= 25'sd8388607 && rpm_q >= -25'sd8388608, "rpm out of range")
	`ASSERT_NEXT(a_div_start, clk, arst_n, div_start, div_busy, "divider did not start")
endmodule

FILE: hdl/espc_ctrl.sv
// Sequencer for edge and tick items; drives the datapath commands.
// Depends on espc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module espc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  logic           in_action,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output espc_pkg::cmd_t cmd,
	input  espc_pkg::sts_t sts
);
	localparam logic [3:0] S_IDLE = 4'd0, S_EDGE = 4'd1, S_CLR = 4'd2, S_SUM = 4'd3,
		S_AVG = 4'd4, S_AVGW = 4'd5, S_QUO = 4'd6, S_QUOW = 4'd7, S_RAW = 4'd8,
		S_EMA = 4'd9, S_ERR = 4'd10, S_MP = 4'd11, S_MI = 4'd12, S_MD = 4'd13,
		S_FIN = 4'd14;
	logic [3:0] state_q, state_d;
	logic ov_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_fire) state_d = in_action ? S_CLR : S_EDGE;
			S_EDGE: begin cmd.edge_upd = 1'b1; state_d = S_IDLE; end
			S_CLR:  begin cmd.sum_clr = 1'b1; state_d = S_SUM; end
			S_SUM:  begin cmd.sum_step = 1'b1; if (sts.sum_last) state_d = S_AVG; end
			S_AVG:  begin cmd.avg_start = 1'b1; state_d = S_AVGW; end
			S_AVGW: if (sts.div_done) state_d = S_QUO;
			S_QUO:  begin cmd.quo_start = 1'b1; state_d = S_QUOW; end
			S_QUOW: if (sts.div_done) state_d = S_RAW;
			S_RAW:  begin cmd.raw_load = 1'b1; state_d = S_EMA; end
			S_EMA:  begin cmd.ema = 1'b1; state_d = S_ERR; end
			S_ERR:  begin cmd.err = 1'b1; state_d = S_MP; end
			S_MP:   begin cmd.mul_p = 1'b1; state_d = S_MI; end
			S_MI:   begin cmd.mul_i = 1'b1; state_d = S_MD; end
			S_MD:   begin cmd.mul_d = 1'b1; state_d = S_FIN; end
			S_FIN:  if (!ov_q) begin cmd.finish = 1'b1; state_d = S_IDLE; end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = ov_q;

	`ASSERT_NEXT(a_fin_valid, clk, arst_n, cmd.finish, ov_q, "result not raised")
	`ASSERT_IMPL(a_hold, clk, arst_n, ov_q && !out_ready, !cmd.finish, "result overwritten")
	`ASSERT_NEXT(a_div_wait, clk, arst_n, state_q == S_AVG, sts.div_busy, "divider idle")
endmodule

FILE: hdl/encoder_speed_pid_controller.sv
// Encoder period averaging, EMA speed filter and PID duty controller.
// Edge and tick beats are accepted only in the idle state, so a new beat waits until the last
// one is done; each tick runs the bit-serial divider twice, for the average period and the speed.
// A tick result becomes valid in the same cycle that s_axis_tready rises again; the result sits in an output
// register, and a later tick waits in its last state until that result is taken.
// arst_n clears ring, speed, integral and previous-error state and loads register defaults.
module encoder_speed_pid_controller #(
	parameter int RING_DEPTH = espc_pkg::RING_DEPTH_DEF,
	parameter int TIME_BITS  = espc_pkg::TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [TIME_BITS-1:0] s_axis_tdata, // time_us
	input  logic        s_axis_tuser,          // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,          // duty[7:0], rpm_filtered[31:8]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	espc_pkg::cmd_t cmd;
	espc_pkg::sts_t sts;
	logic [7:0] duty;
	logic signed [23:0] rpm;
	logic [TIME_BITS-1:0] time_q;
	logic in_fire;

	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk) if (in_fire) time_q <= s_axis_tdata;

	espc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_action(s_axis_tuser),
		.in_ready(s_axis_tready), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.cmd(cmd), .sts(sts)
	);

	espc_datapath #(.RING_DEPTH(RING_DEPTH), .TIME_BITS(TIME_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .time_in(time_q),
		.cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.duty(duty), .rpm_filtered(rpm)
	);

	assign m_axis_tdata = {rpm, duty};
endmodule
